[src/assert_macros.svh]
// Assertion helpers. Both sample on posedge clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define U2E_ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("u2e assertion failed");
`define U2E_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("u2e forbidden condition seen");
`else
`define U2E_ASSERT_CLK(label, prop)
`define U2E_ASSERT_NEVER(label, expr)
`endif

`endif

[src/u2e_pkg.sv]
`timescale 1ns / 1ps

package u2e_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_BSL    = 3'd1,
        PH_TWO    = 3'd2,
        PH_THREE1 = 3'd3,
        PH_THREE2 = 3'd4,
        PH_UESC   = 3'd5
    } phase_t;

    // what closes a command after its bytes
    typedef enum logic [1:0] {
        END_NONE   = 2'd0,
        END_FINISH = 2'd1,
        END_FAIL   = 2'd2
    } end_t;

    localparam int MAX_BYTES = 7;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                cnt;
        end_t                      endc;
    } entry_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U_UP  = 8'h55;
    localparam logic [7:0] CH_U_LO  = 8'h75;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;

    localparam int CFG_QUOTED   = 0;
    localparam int CFG_CAPACITY = 1;

endpackage

[src/u2e_front.sv]
`timescale 1ns / 1ps

module u2e_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic            quoted_mode,
    input  logic            q_full,
    output logic            push,
    output u2e_pkg::entry_t push_entry
);

    typedef struct packed {
        logic              emit;
        logic [7:0]        ch;
        u2e_pkg::end_t     endc;
        u2e_pkg::phase_t   phase;
        logic              hold;
    } fresh_t;

    function automatic fresh_t fresh_f(input logic [7:0] b, input logic last);
        fresh_t f;
        f.emit  = 1'b0;
        f.ch    = b;
        f.endc  = u2e_pkg::END_NONE;
        f.phase = u2e_pkg::PH_IDLE;
        f.hold  = 1'b0;
        if (b == 8'h00) begin
            f.endc = u2e_pkg::END_FINISH;
        end else if (b == u2e_pkg::CH_BSL) begin
            if (last) begin
                f.emit = 1'b1;
                f.endc = u2e_pkg::END_FINISH;
            end else begin
                f.phase = u2e_pkg::PH_BSL;
            end
        end else if (!b[7]) begin
            f.emit = 1'b1;
            if (last)
                f.endc = u2e_pkg::END_FINISH;
        end else if ((b & u2e_pkg::LEAD2_MASK) == u2e_pkg::LEAD2_CODE) begin
            if (last) begin
                f.endc = u2e_pkg::END_FINISH;
            end else begin
                f.hold  = 1'b1;
                f.phase = u2e_pkg::PH_TWO;
            end
        end else if ((b & u2e_pkg::LEAD3_MASK) == u2e_pkg::LEAD3_CODE) begin
            if (last) begin
                f.endc = u2e_pkg::END_FAIL;
            end else begin
                f.hold  = 1'b1;
                f.phase = u2e_pkg::PH_THREE1;
            end
        end else if (last) begin
            // stray continuation or 4-byte lead is dropped
            f.endc = u2e_pkg::END_FINISH;
        end
        return f;
    endfunction

    function automatic logic [7:0] hexd(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
    endfunction

    u2e_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      lead_reg, lead_next;
    logic [7:0]      cont_reg, cont_next;
    logic [7:0]      extra_reg, extra_next;
    logic [2:0]      copy_reg, copy_next;

    logic                                 accept;
    fresh_t                               fr;
    logic                                 use_fresh;
    logic                                 code_en;
    logic [15:0]                          wc;
    logic [1:0]                           k;
    logic [2:0]                           nb;
    logic [u2e_pkg::MAX_BYTES-1:0][7:0]   ent_bytes;
    u2e_pkg::end_t                        endc;
    logic [2:0][7:0]                      held_n;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign fr       = fresh_f(in_byte, in_last);
    assign k        = 2'(3'd4 - copy_reg);

    always_comb
    begin
        phase_next = phase_reg;
        lead_next  = lead_reg;
        cont_next  = cont_reg;
        extra_next = extra_reg;
        copy_next  = copy_reg;
        use_fresh  = 1'b0;
        code_en    = 1'b0;
        wc         = 16'h0000;
        nb         = 3'd0;
        ent_bytes  = '0;
        endc       = u2e_pkg::END_NONE;
        held_n     = '0;
        if (accept)
        begin
            unique case (phase_reg)
                u2e_pkg::PH_BSL:
                begin
                    phase_next = u2e_pkg::PH_IDLE;
                    if (quoted_mode && (in_byte == u2e_pkg::CH_R || in_byte == u2e_pkg::CH_N))
                    begin
                        ent_bytes[nb] = (in_byte == u2e_pkg::CH_R) ? u2e_pkg::CH_CR
                                                                   : u2e_pkg::CH_LF;
                        nb = nb + 3'd1;
                        if (in_last)
                            endc = u2e_pkg::END_FINISH;
                    end
                    else if (quoted_mode &&
                             (in_byte == u2e_pkg::CH_QUOTE || in_byte == u2e_pkg::CH_BSL))
                    begin
                        use_fresh = 1'b1;
                    end
                    else if (in_byte == u2e_pkg::CH_U_LO)
                    begin
                        if (in_last)
                        begin
                            ent_bytes[0] = u2e_pkg::CH_BSL;
                            ent_bytes[1] = u2e_pkg::CH_U_LO;
                            nb = 3'd2;
                            endc = u2e_pkg::END_FINISH;
                        end
                        else
                        begin
                            phase_next = u2e_pkg::PH_UESC;
                            copy_next  = 3'd4;
                        end
                    end
                    else
                    begin
                        ent_bytes[nb] = u2e_pkg::CH_BSL;
                        nb = nb + 3'd1;
                        use_fresh = 1'b1;
                    end
                end
                u2e_pkg::PH_TWO:
                begin
                    phase_next = u2e_pkg::PH_IDLE;
                    code_en    = 1'b1;
                    wc         = {5'b00000, lead_reg[4:0], in_byte[5:0]};
                    if (in_last)
                        endc = u2e_pkg::END_FINISH;
                end
                u2e_pkg::PH_THREE1:
                begin
                    if (in_last)
                    begin
                        phase_next = u2e_pkg::PH_IDLE;
                        endc       = u2e_pkg::END_FAIL;
                    end
                    else
                    begin
                        cont_next  = in_byte;
                        phase_next = u2e_pkg::PH_THREE2;
                    end
                end
                u2e_pkg::PH_THREE2:
                begin
                    phase_next = u2e_pkg::PH_IDLE;
                    code_en    = 1'b1;
                    wc         = {lead_reg[3:0], cont_reg[5:0], in_byte[5:0]};
                    if (in_last)
                        endc = u2e_pkg::END_FINISH;
                end
                u2e_pkg::PH_UESC:
                begin
                    if (copy_reg == 3'd1)
                    begin
                        phase_next   = u2e_pkg::PH_IDLE;
                        copy_next    = 3'd0;
                        ent_bytes[0] = u2e_pkg::CH_BSL;
                        ent_bytes[1] = u2e_pkg::CH_U_UP;
                        ent_bytes[2] = u2e_pkg::CH_PLUS;
                        ent_bytes[3] = lead_reg;
                        ent_bytes[4] = cont_reg;
                        ent_bytes[5] = extra_reg;
                        ent_bytes[6] = in_byte;
                        nb = 3'd7;
                        if (in_last)
                            endc = u2e_pkg::END_FINISH;
                    end
                    else
                    begin
                        case (k)
                            2'd0:    lead_next  = in_byte;
                            2'd1:    cont_next  = in_byte;
                            default: extra_next = in_byte;
                        endcase
                        copy_next = copy_reg - 3'd1;
                        if (in_last)
                        begin
                            // truncated escape goes out literally
                            phase_next = u2e_pkg::PH_IDLE;
                            copy_next  = 3'd0;
                            held_n[0]  = lead_next;
                            held_n[1]  = cont_next;
                            held_n[2]  = extra_next;
                            ent_bytes[0] = u2e_pkg::CH_BSL;
                            ent_bytes[1] = u2e_pkg::CH_U_LO;
                            nb = 3'd2;
                            for (int i = 0; i < 3; i++)
                            begin
                                if (2'(i) <= k)
                                begin
                                    ent_bytes[nb] = held_n[i];
                                    nb = nb + 3'd1;
                                end
                            end
                            endc = u2e_pkg::END_FINISH;
                        end
                    end
                end
                default:
                begin
                    use_fresh = 1'b1;
                end
            endcase

            if (use_fresh)
            begin
                phase_next = fr.phase;
                if (fr.hold)
                    lead_next = in_byte;
                if (fr.emit)
                begin
                    ent_bytes[nb] = fr.ch;
                    nb = nb + 3'd1;
                end
                endc = fr.endc;
            end

            if (code_en)
            begin
                ent_bytes[0] = u2e_pkg::CH_BSL;
                ent_bytes[1] = u2e_pkg::CH_U_UP;
                ent_bytes[2] = u2e_pkg::CH_PLUS;
                ent_bytes[3] = hexd(wc[15:12]);
                ent_bytes[4] = hexd(wc[11:8]);
                ent_bytes[5] = hexd(wc[7:4]);
                ent_bytes[6] = hexd(wc[3:0]);
                nb = 3'd7;
            end
        end
    end

    assign push             = accept && (nb != 3'd0 || endc != u2e_pkg::END_NONE);
    assign push_entry.bytes = ent_bytes;
    assign push_entry.cnt   = nb;
    assign push_entry.endc  = endc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= u2e_pkg::PH_IDLE;
            lead_reg  <= 8'h00;
            cont_reg  <= 8'h00;
            extra_reg <= 8'h00;
            copy_reg  <= 3'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            lead_reg  <= lead_next;
            cont_reg  <= cont_next;
            extra_reg <= extra_next;
            copy_reg  <= copy_next;
        end
    end

endmodule

[src/u2e_queue.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u2e_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u2e_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output u2e_pkg::entry_t head
);

    u2e_pkg::entry_t                     mem_reg [u2e_pkg::QUEUE_DEPTH];
    logic [u2e_pkg::QPTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [u2e_pkg::QPTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [u2e_pkg::QCNT_W-1:0]          count_reg, count_next;

    assign full  = (count_reg == u2e_pkg::QCNT_W'(u2e_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    `U2E_ASSERT_NEVER(a_q_overrun, push && full)
    `U2E_ASSERT_NEVER(a_q_underrun, pop && empty)
    `U2E_ASSERT_CLK(a_q_count_up, push && !pop |=> count_reg == $past(count_reg) + 1'b1)

endmodule

[src/u2e_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u2e_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     out_capacity,
    input  logic            q_empty,
    input  u2e_pkg::entry_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            overflow_error
);

    localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;
    localparam logic [COUNT_BITS-1:0] BW_MAX = '1;

    logic [2:0]            pos_reg, pos_next;
    logic [COUNT_BITS-1:0] bw_reg, bw_next;
    logic                  done_reg, done_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_err_reg, out_err_next;

    logic             can_load;
    logic [CMP_W-1:0] bw_ext, cap_ext;
    logic             over1, over2;

    assign can_load = !out_valid_reg || out_ready;
    assign bw_ext   = CMP_W'(bw_reg);
    assign cap_ext  = CMP_W'(out_capacity);
    assign over1    = (bw_ext + CMP_W'(1)) > cap_ext;
    assign over2    = (bw_ext + CMP_W'(2)) > cap_ext;

    always_comb
    begin
        pop            = 1'b0;
        pos_next       = pos_reg;
        bw_next        = bw_reg;
        done_next      = done_reg;
        out_valid_next = can_load ? 1'b0 : out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        if (!q_empty)
        begin
            if (done_reg)
            begin
                // stream closed: drain without output
                pop      = 1'b1;
                pos_next = 3'd0;
            end
            else if (can_load)
            begin
                out_valid_next = 1'b1;
                if (pos_reg < head.cnt)
                begin
                    if (over2)
                    begin
                        out_byte_next = 8'h00;
                        out_last_next = 1'b1;
                        out_err_next  = 1'b1;
                        done_next     = 1'b1;
                        pop           = 1'b1;
                        pos_next      = 3'd0;
                    end
                    else
                    begin
                        out_byte_next = head.bytes[pos_reg];
                        out_last_next = 1'b0;
                        out_err_next  = 1'b0;
                        if (bw_reg != BW_MAX)
                            bw_next = bw_reg + 1'b1;
                        if (pos_reg == head.cnt - 3'd1 && head.endc == u2e_pkg::END_NONE)
                        begin
                            pop      = 1'b1;
                            pos_next = 3'd0;
                        end
                        else
                        begin
                            pos_next = pos_reg + 3'd1;
                        end
                    end
                end
                else
                begin
                    out_byte_next = 8'h00;
                    out_last_next = 1'b1;
                    done_next     = 1'b1;
                    pop           = 1'b1;
                    pos_next      = 3'd0;
                    case (head.endc)
                        u2e_pkg::END_FINISH: out_err_next = over1;
                        default:             out_err_next = 1'b1;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 3'd0;
            bw_reg        <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            bw_reg        <= bw_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_last       = out_last_reg;
    assign overflow_error = out_err_reg;

    `U2E_ASSERT_CLK(a_done_quiet, done_reg && can_load |=> !out_valid_reg)
    `U2E_ASSERT_CLK(a_last_zero, out_valid_reg && out_last_reg |-> out_byte_reg == 8'h00)
    `U2E_ASSERT_CLK(a_err_last, out_valid_reg && out_err_reg |-> out_last_reg)
    `U2E_ASSERT_CLK(a_last_done, out_valid_reg && out_last_reg |-> done_reg)

endmodule

[src/utf8_to_unicode_escape_converter.sv]
`timescale 1ns / 1ps
// UTF-8 to \U+XXXX escape converter.
// Input channel (in_valid/in_ready): one source byte per transfer, in_last on
// the final byte. Output channel (out_valid/out_ready): one converted byte per
// transfer; out_last marks the terminating zero or the error result, with
// overflow_error set on the error result. Config channel (cfg_valid/cfg_ready,
// always ready): index 0 = quoted mode (bit 0), index 1 = output capacity.
// Write config only while the converter is idle.
// Throughput: one input byte per cycle while the queue is not full; one output
// byte per cycle while out_ready is high. An input byte that expands to N output
// bytes holds the output side while those N bytes go out, and a 4-entry command
// queue between decoder and serializer absorbs the burst. The output is registered.
// Once the terminator or error result is produced, all further input is taken
// and dropped until reset. Reset returns the decoder to idle, clears the byte
// count and the done flag, and restores config to quoted off and capacity
// 65535. When out_ready is low the output register holds; the queue fills and
// then in_ready drops.
module utf8_to_unicode_escape_converter #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        overflow_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic        quoted_reg;
    logic [15:0] cap_reg;

    logic            q_full;
    logic            q_empty;
    logic            push;
    logic            pop;
    u2e_pkg::entry_t push_entry;
    u2e_pkg::entry_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoted_reg <= 1'b0;
            cap_reg    <= 16'hFFFF;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == 1'(u2e_pkg::CFG_QUOTED))
                quoted_reg <= cfg_data[0];
            else
                cap_reg <= cfg_data;
        end
    end

    u2e_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .quoted_mode (quoted_reg),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    u2e_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head)
    );

    u2e_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .out_capacity   (cap_reg),
        .q_empty        (q_empty),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .out_last       (out_last),
        .overflow_error (overflow_error)
    );

endmodule

[test/utf8_to_unicode_escape_converter_test.sv]
`timescale 1ns / 1ps

module utf8_to_unicode_escape_converter_test;

    localparam int COUNT_BITS    = 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 200;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_PAD   = 8'h61;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       err;
    } out_beat_t;

    typedef logic [7:0] byte_q_t[$];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'h00;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        overflow_error;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = 16'h0000;

    // converter state as predicted
    logic             quoted_on = 1'b0;
    logic [15:0]      capacity = 16'hFFFF;
    u2e_pkg::phase_t  decode_state = u2e_pkg::PH_IDLE;
    logic [7:0]       lead_byte = 8'h00;
    logic [7:0]       cont_byte = 8'h00;
    logic [7:0]       extra_byte = 8'h00;
    logic [2:0]       copy_left = 3'd0;
    int unsigned      written_count = 0;
    logic             stream_ended = 1'b0;
    int               step_results = 0;

    out_beat_t   expected_bytes[$];
    int          error_count = 0;
    int          cycle_count = 0;
    logic        steady = 1'b0;
    logic        hold_request = 1'b0;

    utf8_to_unicode_escape_converter #(
        .COUNT_BITS(COUNT_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_byte(in_byte),
        .in_last(in_last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .out_last(out_last),
        .overflow_error(overflow_error),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- converter prediction ----------------

    function automatic void push_result(logic [7:0] b, logic l, logic e);
        out_beat_t beat;
        if (step_results >= 8)
            return;
        beat.data = b;
        beat.last = l;
        beat.err  = e;
        expected_bytes.push_back(beat);
        step_results++;
    endfunction

    function automatic void raise_error();
        if (stream_ended)
            return;
        push_result(8'h00, 1'b1, 1'b1);
        stream_ended = 1'b1;
    endfunction

    // one output byte, needs room for itself plus the terminator
    function automatic void emit_char(logic [7:0] b);
        if (stream_ended)
            return;
        if (written_count + 2 > capacity)
        begin
            raise_error();
            return;
        end
        push_result(b, 1'b0, 1'b0);
        if (written_count < (1 << COUNT_BITS) - 1)
            written_count++;
    endfunction

    function automatic void emit_terminator();
        if (stream_ended)
            return;
        if (written_count + 1 > capacity)
        begin
            raise_error();
            return;
        end
        push_result(8'h00, 1'b1, 1'b0);
        stream_ended = 1'b1;
    endfunction

    function automatic logic [7:0] hex_digit(logic [3:0] v);
        return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_A_UP + 8'(v - 4'd10);
    endfunction

    function automatic void emit_code_point(logic [15:0] wc);
        emit_char(u2e_pkg::CH_BSL);
        emit_char(u2e_pkg::CH_U_UP);
        emit_char(u2e_pkg::CH_PLUS);
        emit_char(hex_digit(wc[15:12]));
        emit_char(hex_digit(wc[11:8]));
        emit_char(hex_digit(wc[7:4]));
        emit_char(hex_digit(wc[3:0]));
    endfunction

    function automatic void decode_fresh(logic [7:0] b, logic l);
        decode_state = u2e_pkg::PH_IDLE;
        if (b == 8'h00)
            emit_terminator();
        else if (b == u2e_pkg::CH_BSL)
        begin
            if (l)
            begin
                emit_char(u2e_pkg::CH_BSL);
                emit_terminator();
            end
            else
                decode_state = u2e_pkg::PH_BSL;
        end
        else if (b < 8'h80)
        begin
            emit_char(b);
            if (l)
                emit_terminator();
        end
        else if ((b & u2e_pkg::LEAD2_MASK) == u2e_pkg::LEAD2_CODE)
        begin
            if (l)
                emit_terminator();
            else
            begin
                lead_byte = b;
                decode_state = u2e_pkg::PH_TWO;
            end
        end
        else if ((b & u2e_pkg::LEAD3_MASK) == u2e_pkg::LEAD3_CODE)
        begin
            if (l)
                raise_error();
            else
            begin
                lead_byte = b;
                decode_state = u2e_pkg::PH_THREE1;
            end
        end
        else if (l)
            emit_terminator();
    endfunction

    function automatic void convert_byte(logic [7:0] b, logic l);
        logic [1:0] slot;
        logic [7:0] held [3];
        step_results = 0;
        if (stream_ended)
            return;
        case (decode_state)
            u2e_pkg::PH_BSL:
            begin
                decode_state = u2e_pkg::PH_IDLE;
                if (quoted_on && (b == u2e_pkg::CH_QUOTE || b == u2e_pkg::CH_BSL ||
                                  b == u2e_pkg::CH_R || b == u2e_pkg::CH_N))
                begin
                    if (b == u2e_pkg::CH_R || b == u2e_pkg::CH_N)
                    begin
                        emit_char((b == u2e_pkg::CH_R) ? u2e_pkg::CH_CR : u2e_pkg::CH_LF);
                        if (l)
                            emit_terminator();
                    end
                    else
                        decode_fresh(b, l);
                end
                else if (b == u2e_pkg::CH_U_LO)
                begin
                    if (l)
                    begin
                        emit_char(u2e_pkg::CH_BSL);
                        emit_char(u2e_pkg::CH_U_LO);
                        emit_terminator();
                    end
                    else
                    begin
                        decode_state = u2e_pkg::PH_UESC;
                        copy_left = 3'd4;
                    end
                end
                else
                begin
                    emit_char(u2e_pkg::CH_BSL);
                    decode_fresh(b, l);
                end
            end
            u2e_pkg::PH_TWO:
            begin
                decode_state = u2e_pkg::PH_IDLE;
                emit_code_point({5'b0, lead_byte[4:0], b[5:0]});
                if (l)
                    emit_terminator();
            end
            u2e_pkg::PH_THREE1:
            begin
                if (l)
                begin
                    decode_state = u2e_pkg::PH_IDLE;
                    raise_error();
                end
                else
                begin
                    cont_byte = b;
                    decode_state = u2e_pkg::PH_THREE2;
                end
            end
            u2e_pkg::PH_THREE2:
            begin
                decode_state = u2e_pkg::PH_IDLE;
                emit_code_point({lead_byte[3:0], cont_byte[5:0], b[5:0]});
                if (l)
                    emit_terminator();
            end
            u2e_pkg::PH_UESC:
            begin
                slot = 2'(3'd4 - copy_left);
                if (copy_left == 3'd1)
                begin
                    decode_state = u2e_pkg::PH_IDLE;
                    copy_left = 3'd0;
                    emit_char(u2e_pkg::CH_BSL);
                    emit_char(u2e_pkg::CH_U_UP);
                    emit_char(u2e_pkg::CH_PLUS);
                    emit_char(lead_byte);
                    emit_char(cont_byte);
                    emit_char(extra_byte);
                    emit_char(b);
                    if (l)
                        emit_terminator();
                end
                else
                begin
                    if (slot == 2'd0)
                        lead_byte = b;
                    else if (slot == 2'd1)
                        cont_byte = b;
                    else
                        extra_byte = b;
                    copy_left = copy_left - 3'd1;
                    // cut short: flush backslash, u and what was held
                    if (l)
                    begin
                        held[0] = lead_byte;
                        held[1] = cont_byte;
                        held[2] = extra_byte;
                        decode_state = u2e_pkg::PH_IDLE;
                        copy_left = 3'd0;
                        emit_char(u2e_pkg::CH_BSL);
                        emit_char(u2e_pkg::CH_U_LO);
                        for (int i = 0; i <= slot && i < 3; i++)
                            emit_char(held[i]);
                        emit_terminator();
                    end
                end
            end
            default:
                decode_fresh(b, l);
        endcase
    endfunction

    // ---------------- output side ----------------

    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3))
                                          : int'($urandom_range(6, 30));
    endfunction

    initial
    begin : output_stall
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : output_check
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected transfer: out_byte %02h out_last %0b overflow_error %0b",
                       out_byte, out_last, overflow_error);
                error_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte expected %02h actual %02h", want.data, out_byte);
                    error_count++;
                end
                if (out_last !== want.last)
                begin
                    $error("out_last expected %0b actual %0b", want.last, out_last);
                    error_count++;
                end
                if (overflow_error !== want.err)
                begin
                    $error("overflow_error expected %0b actual %0b", want.err, overflow_error);
                    error_count++;
                end
            end
        end
    end

    // ---------------- input side ----------------

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        do
            @(posedge clk);
        while (!in_ready);
        convert_byte(b, l);
    endtask

    // a zero where a fresh byte is expected would end the stream early
    task automatic send_bytes(input byte_q_t seq);
        logic [7:0] b;
        foreach (seq[i])
        begin
            b = seq[i];
            if (b == 8'h00 && !stream_ended &&
                (decode_state == u2e_pkg::PH_IDLE || decode_state == u2e_pkg::PH_BSL))
                b = CH_PAD;
            send_byte(b, 1'b0);
        end
    endtask

    task automatic drain_results();
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input int idx, input logic [15:0] value);
        while (!stream_ended && decode_state != u2e_pkg::PH_IDLE)
            send_byte(CH_PAD, 1'b0);
        in_valid <= 1'b0;
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= 1'(idx);
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == u2e_pkg::CFG_QUOTED)
            quoted_on = value[0];
        else
            capacity = value;
    endtask

    function automatic logic [7:0] ascii_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 127));
        return (c == u2e_pkg::CH_BSL) ? CH_SLASH : c;
    endfunction

    // ---------------- tests ----------------

    task automatic test_ascii_and_stray();
        byte_q_t seq;
        write_register(u2e_pkg::CFG_QUOTED, 16'd0);
        write_register(u2e_pkg::CFG_CAPACITY, 16'hFFFF);
        seq = {8'h01, 8'h7F, 8'h80, 8'hFF};
        send_bytes(seq);
    endtask

    task automatic test_two_byte();
        byte_q_t seq;
        // zero taken as continuation
        seq = {8'hC0, 8'h00, 8'hDF, 8'hFF};
        send_bytes(seq);
    endtask

    task automatic test_three_byte();
        byte_q_t seq;
        seq = {8'hEF, 8'hBF, 8'hBF};
        send_bytes(seq);
    endtask

    task automatic test_escapes();
        byte_q_t seq;
        seq = {u2e_pkg::CH_BSL, u2e_pkg::CH_U_LO, 8'h00, 8'h41, 8'hFF, 8'h37,
               u2e_pkg::CH_BSL, u2e_pkg::CH_BSL, u2e_pkg::CH_N};
        send_bytes(seq);
    endtask

    task automatic test_quoted_unescape();
        byte_q_t seq;
        write_register(u2e_pkg::CFG_QUOTED, 16'd1);
        seq = {u2e_pkg::CH_BSL, u2e_pkg::CH_QUOTE, u2e_pkg::CH_BSL, u2e_pkg::CH_BSL,
               u2e_pkg::CH_R, u2e_pkg::CH_BSL, u2e_pkg::CH_N};
        send_bytes(seq);
    endtask

    task automatic send_random_sequence(inout int sent);
        byte_q_t    seq;
        logic [7:0] specials [4] = '{u2e_pkg::CH_QUOTE, u2e_pkg::CH_BSL,
                                     u2e_pkg::CH_R, u2e_pkg::CH_N};
        case ($urandom_range(0, 9))
            0, 1: repeat ($urandom_range(1, 4)) seq.push_back(ascii_char());
            2: seq = {8'($urandom_range(8'hC0, 8'hDF)), 8'($urandom)};
            3: seq = {8'($urandom_range(8'hE0, 8'hEF)), 8'($urandom), 8'($urandom)};
            4: seq = {8'($urandom_range(8'hE0, 8'hEF)), 8'($urandom_range(8'h80, 8'hBF)),
                      8'($urandom_range(8'h80, 8'hBF))};
            5, 6: seq = {u2e_pkg::CH_BSL, u2e_pkg::CH_U_LO, 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom)};
            7: seq = {u2e_pkg::CH_BSL, ascii_char()};
            8: seq = {u2e_pkg::CH_BSL, specials[$urandom_range(0, 3)]};
            default: seq.push_back(8'($urandom_range(1, 255)));
        endcase
        send_bytes(seq);
        sent += seq.size();
    endtask

    task automatic test_random_traffic();
        int sent;
        for (int p = 0; p < 5; p++)
        begin
            write_register(u2e_pkg::CFG_QUOTED, 16'(p % 2));
            if (p == 2)
                write_register(u2e_pkg::CFG_CAPACITY, 16'hFFFF);
            else
                write_register(u2e_pkg::CFG_CAPACITY,
                               16'($urandom_range(written_count + 4000, 65535)));
            steady = (p == 1 || p == 3);
            // long output hold-off while input keeps coming
            if (p == 1)
                hold_request = 1'b1;
            sent = 0;
            while (sent < 60)
                send_random_sequence(sent);
        end
        steady = 1'b0;
    endtask

    // only one way to end the stream per run, picked at random
    task automatic test_stream_end();
        byte_q_t seq;
        int      cut;
        write_register(u2e_pkg::CFG_QUOTED, 16'($urandom_range(0, 1)));
        case ($urandom_range(0, 6))
            0:
            begin
                // room for exactly two more bytes before the terminator
                write_register(u2e_pkg::CFG_CAPACITY, 16'(written_count + 3));
                seq = {8'h78, 8'hC3, 8'hA9};
                send_bytes(seq);
            end
            1: send_byte(8'h00, 1'b0);
            2: send_byte(8'h5A, 1'b1);
            3: send_byte(8'hC5, 1'b1);
            4:
            begin
                send_byte(8'hE4, 1'($urandom_range(0, 1)));
                send_byte(8'h88, 1'b1);
            end
            5:
            begin
                seq = {u2e_pkg::CH_BSL, u2e_pkg::CH_U_LO, 8'h00, 8'h31, 8'hFE};
                cut = $urandom_range(1, 4);
                for (int i = 0; i <= cut; i++)
                    send_byte(seq[i], i == cut);
            end
            default: send_byte(u2e_pkg::CH_BSL, 1'b1);
        endcase
        write_register(u2e_pkg::CFG_CAPACITY, 16'd1);
        // stream is over: these are taken and dropped
        repeat (6) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ascii_and_stray();
        test_two_byte();
        test_three_byte();
        test_escapes();
        test_quoted_unescape();
        test_random_traffic();
        test_stream_end();
        in_valid <= 1'b0;
        drain_results();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[utf8_to_unicode_escape_converter.f]
+incdir+src
src/u2e_pkg.sv
src/u2e_front.sv
src/u2e_queue.sv
src/u2e_back.sv
src/utf8_to_unicode_escape_converter.sv
test/utf8_to_unicode_escape_converter_test.sv
